// File: src/pnp_pkg.sv
// Shared types and constants for the point-near-polyline check.
// No dependencies; used by every module of the block.
package pnp_pkg;

   localparam int COORD_W  = 12;
   localparam int RAD_W    = 8;
   localparam int R_W      = 9;
   localparam int R2_W     = 18;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // Segment unit widths: differences, products, squared lengths, cross terms
   localparam int DIFF_W   = 13;
   localparam int PROD_W   = 26;
   localparam int SQ_W     = 24;
   localparam int SUM_W    = 25;
   localparam int DOT_W    = 26;
   localparam int CROSS2_W = 50;
   localparam int RL_W     = 43;
   localparam int SEG_LAT  = 5;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [0:0] CSR_IDX_PATH_HALF_WIDTH = 1'b0;
   localparam logic [RAD_W-1:0] PATH_HALF_WIDTH_RESET = 8'd10;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } vertex_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic       valid;
      vertex_type pt;
      vertex_type a;
      vertex_type b;
   } seg_req_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } seg_rsp_type;

endpackage

// File: src/pnp_cell.sv
// One vertex cell of the rotating vertex ring.
// Depends on pnp_pkg for the vertex and control types.
module pnp_cell (
   input  logic                  clock,
   input  pnp_pkg::cell_ctl_type ctl,
   input  pnp_pkg::vertex_type   next_vtx,
   input  pnp_pkg::vertex_type   load_vtx,
   output pnp_pkg::vertex_type   vtx
);

   pnp_pkg::vertex_type vtx_ff;
   pnp_pkg::vertex_type vtx_in;

   // load wins over shift; they never coincide
   always_comb begin
      vtx_in = vtx_ff;
      if (ctl.load) begin
         vtx_in = load_vtx;
      end else if (ctl.shift) begin
         vtx_in = next_vtx;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff <= vtx_in;
   end

   assign vtx = vtx_ff;

endmodule

// File: src/pnp_seg.sv
// Pipelined point-to-segment proximity test, five register stages.
// Depends on pnp_pkg for widths and request/response types.
module pnp_seg (
   input  logic                           clock,
   input  logic                           reset,
   input  pnp_pkg::seg_req_type           req,
   input  logic [pnp_pkg::R2_W-1:0]       r2,
   output pnp_pkg::seg_rsp_type           rsp
);

   localparam int DW = pnp_pkg::DIFF_W;
   localparam int PW = pnp_pkg::PROD_W;
   localparam int SW = pnp_pkg::SUM_W;
   localparam int XW = 2 * pnp_pkg::DOT_W;

   // stage 1: differences
   logic                 s1_valid_ff;
   logic signed [DW-1:0] qax_ff, qay_ff, qbx_ff, qby_ff, dx_ff, dy_ff;
   logic signed [DW-1:0] qax_in, qay_in, qbx_in, qby_in, dx_in, dy_in;

   assign qax_in = $signed({1'b0, req.pt.x}) - $signed({1'b0, req.a.x});
   assign qay_in = $signed({1'b0, req.pt.y}) - $signed({1'b0, req.a.y});
   assign qbx_in = $signed({1'b0, req.pt.x}) - $signed({1'b0, req.b.x});
   assign qby_in = $signed({1'b0, req.pt.y}) - $signed({1'b0, req.b.y});
   assign dx_in  = $signed({1'b0, req.b.x})  - $signed({1'b0, req.a.x});
   assign dy_in  = $signed({1'b0, req.b.y})  - $signed({1'b0, req.a.y});

   // stage 2: products
   logic                 s2_valid_ff;
   logic signed [PW-1:0] sqax_ff, sqay_ff, sqbx_ff, sqby_ff, sdx_ff, sdy_ff;
   logic signed [PW-1:0] pxdx_ff, pydy_ff, pxdy_ff, pydx_ff;

   // stage 3: sums and endpoint compares
   logic                 s3_valid_ff;
   logic                 near3_ff;
   logic [SW-1:0]        len2_ff;
   logic signed [pnp_pkg::DOT_W-1:0] dot_ff, cross_ff;
   logic [SW-1:0]        da2_in, db2_in, len2_in;

   assign da2_in  = SW'(sqax_ff[pnp_pkg::SQ_W-1:0]) + SW'(sqay_ff[pnp_pkg::SQ_W-1:0]);
   assign db2_in  = SW'(sqbx_ff[pnp_pkg::SQ_W-1:0]) + SW'(sqby_ff[pnp_pkg::SQ_W-1:0]);
   assign len2_in = SW'(sdx_ff[pnp_pkg::SQ_W-1:0]) + SW'(sdy_ff[pnp_pkg::SQ_W-1:0]);

   // stage 4: squared cross term, scaled radius, projection range
   logic                          s4_valid_ff;
   logic                          near4_ff;
   logic                          in_range_ff;
   logic [pnp_pkg::CROSS2_W-1:0]  cross2_ff;
   logic [pnp_pkg::RL_W-1:0]      rl_ff;
   logic signed [XW-1:0]          cross_sq;
   logic [pnp_pkg::RL_W-1:0]      rl_in;
   logic                          in_range_in;

   assign cross_sq    = XW'(cross_ff) * XW'(cross_ff);
   assign rl_in       = pnp_pkg::RL_W'(r2) * pnp_pkg::RL_W'(len2_ff);
   assign in_range_in = !dot_ff[pnp_pkg::DOT_W-1] && (dot_ff[SW-1:0] <= len2_ff);

   // stage 5: verdict
   logic s5_valid_ff;
   logic hit_ff;
   logic hit_in;

   // zero-length segment: cross and rl are both zero, so only the endpoints count
   assign hit_in = near4_ff ||
                   (in_range_ff && (cross2_ff < pnp_pkg::CROSS2_W'(rl_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      qax_ff <= qax_in;
      qay_ff <= qay_in;
      qbx_ff <= qbx_in;
      qby_ff <= qby_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;

      sqax_ff <= PW'(qax_ff) * PW'(qax_ff);
      sqay_ff <= PW'(qay_ff) * PW'(qay_ff);
      sqbx_ff <= PW'(qbx_ff) * PW'(qbx_ff);
      sqby_ff <= PW'(qby_ff) * PW'(qby_ff);
      sdx_ff  <= PW'(dx_ff) * PW'(dx_ff);
      sdy_ff  <= PW'(dy_ff) * PW'(dy_ff);
      pxdx_ff <= PW'(qax_ff) * PW'(dx_ff);
      pydy_ff <= PW'(qay_ff) * PW'(dy_ff);
      pxdy_ff <= PW'(qax_ff) * PW'(dy_ff);
      pydx_ff <= PW'(qay_ff) * PW'(dx_ff);

      near3_ff <= (da2_in < SW'(r2)) || (db2_in < SW'(r2));
      len2_ff  <= len2_in;
      dot_ff   <= pxdx_ff + pydy_ff;
      cross_ff <= pxdy_ff - pydx_ff;

      near4_ff    <= near3_ff;
      in_range_ff <= in_range_in;
      cross2_ff   <= cross_sq[pnp_pkg::CROSS2_W-1:0];
      rl_ff       <= rl_in;

      hit_ff <= hit_in;
   end

   assign rsp.valid = s5_valid_ff;
   assign rsp.hit   = hit_ff;

endmodule

// File: src/point_near_polyline_check_top.sv
// Top level of the point-near-polyline check: vertex ring, sequencer, CSR port.
// Depends on pnp_pkg, pnp_cell and pnp_seg.
//
// Usage:
//  - req_ channel carries one item: opcode (clear, append, query), a point and
//    an object radius. rsp_ channel returns one item per request: hit, status.
//  - CSR port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//    path_half_width at byte address 0; pready is tied high.
//  - Clear, append, short-path queries and unused opcodes answer in the next cycle.
//  - A query on a path of two or more vertices rotates the whole vertex ring
//    once past the segment unit, one vertex per cycle, then drains the
//    5-stage segment pipeline; the scan always covers the full ring,
//    independent of how many vertices are stored.
//  - One item is in flight at a time; req_ready drops during a query scan.
//  - The result sits in an output register; a new item is taken in the same
//    cycle the held result leaves. If the receiver stalls, hold the result
//    and stop accepting until it is taken.
//  - Synchronous reset empties the path, drops any pending result and
//    restores path_half_width to 10. The vertex ring itself is not cleared.
module point_near_polyline_check_top #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pnp_pkg::OP_W-1:0]          req_opcode,
   input  logic [pnp_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [pnp_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [pnp_pkg::RAD_W-1:0]         req_object_radius,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [pnp_pkg::STATUS_W-1:0]      rsp_status,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pnp_pkg::CSR_AW-1:0]        paddr,
   input  logic [pnp_pkg::CSR_DW-1:0]        pwdata,
   output logic [pnp_pkg::CSR_DW-1:0]        prdata,
   output logic                              pready
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int STEP_W = $clog2(MAX_POINTS + pnp_pkg::SEG_LAT);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // ---------------------------------------------------------------
   // CSR: path_half_width
   // ---------------------------------------------------------------
   logic [pnp_pkg::RAD_W-1:0] phw_ff;
   logic [pnp_pkg::RAD_W-1:0] phw_in;
   logic                      csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[2:2] == pnp_pkg::CSR_IDX_PATH_HALF_WIDTH);
   assign prdata  = csr_sel ? pnp_pkg::CSR_DW'(phw_ff) : '0;

   always_comb begin
      phw_in = phw_ff;
      if (psel && penable && pwrite && pready && csr_sel) begin
         phw_in = pwdata[pnp_pkg::RAD_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------
   logic                          state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          hit_acc_ff, hit_acc_in;
   pnp_pkg::vertex_type           qpt_ff, qpt_in;
   logic [pnp_pkg::R2_W-1:0]      r2_ff, r2_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [pnp_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic                          append_we;
   logic                          scan_shift;
   logic                          scan_done;
   logic [pnp_pkg::R_W-1:0]       r_sum;
   pnp_pkg::vertex_type           req_vtx;
   pnp_pkg::seg_req_type          seg_req;
   pnp_pkg::seg_rsp_type          seg_rsp;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign req_vtx   = '{y: req_coord_y, x: req_coord_x};
   assign r_sum     = pnp_pkg::R_W'(req_object_radius) + pnp_pkg::R_W'(phw_ff);

   // advance the ring while the step counter is below the ring length
   assign scan_shift = (state_ff == ST_SCAN) && (step_ff < STEP_W'(MAX_POINTS));
   assign scan_done  = (state_ff == ST_SCAN) &&
                       (step_ff == STEP_W'(MAX_POINTS + pnp_pkg::SEG_LAT - 1));

   assign append_we = accept && (req_opcode == pnp_pkg::OP_APPEND) &&
                      (count_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      hit_acc_in    = hit_acc_ff;
      qpt_in        = qpt_ff;
      r2_in         = r2_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;

      // drop the held result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_hit_in    = 1'b0;
         rsp_status_in = pnp_pkg::STATUS_OK;
         case (req_opcode)
            pnp_pkg::OP_CLEAR: begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
            end
            pnp_pkg::OP_APPEND: begin
               if (append_we) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  rsp_status_in = pnp_pkg::STATUS_FULL;
               end
               rsp_valid_in = 1'b1;
            end
            pnp_pkg::OP_QUERY: begin
               if (count_ff < CNT_W'(2)) begin
                  rsp_status_in = pnp_pkg::STATUS_SHORT;
                  rsp_valid_in  = 1'b1;
               end else begin
                  // latch the point and squared reach, start the ring rotation
                  state_in   = ST_SCAN;
                  step_in    = '0;
                  hit_acc_in = 1'b0;
                  qpt_in     = req_vtx;
                  r2_in      = pnp_pkg::R2_W'(r_sum) * pnp_pkg::R2_W'(r_sum);
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (state_ff == ST_SCAN) begin
         step_in = step_ff + STEP_W'(1);
         if (seg_rsp.valid && seg_rsp.hit) begin
            hit_acc_in = 1'b1;
         end
         if (scan_done) begin
            // last verdict slot of the scan arrives this cycle; fold it in and answer
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = hit_acc_ff || (seg_rsp.valid && seg_rsp.hit);
            rsp_status_in = pnp_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phw_ff       <= pnp_pkg::PATH_HALF_WIDTH_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         hit_acc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phw_ff       <= phw_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         hit_acc_ff   <= hit_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qpt_ff        <= qpt_in;
      r2_ff         <= r2_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

   // ---------------------------------------------------------------
   // Vertex ring: cell i takes cell i+1 on every shift of a scan, so after
   // MAX_POINTS shifts every vertex is back in place. Cells 0 and 1 always
   // hold the current segment's endpoints.
   // ---------------------------------------------------------------
   pnp_pkg::vertex_type cell_vtx [MAX_POINTS];

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pnp_pkg::cell_ctl_type ctl;

      assign ctl.shift = scan_shift;
      assign ctl.load  = append_we && (count_ff[IDX_W-1:0] == IDX_W'(i));

      pnp_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .next_vtx (cell_vtx[(i + 1) % MAX_POINTS]),
         .load_vtx (req_vtx),
         .vtx      (cell_vtx[i])
      );
   end

   // ---------------------------------------------------------------
   // Segment unit: feed only segments whose both ends are stored
   // ---------------------------------------------------------------
   assign seg_req.valid = scan_shift &&
                          ((32'(step_ff) + 32'd1) < 32'(count_ff));
   assign seg_req.pt    = qpt_ff;
   assign seg_req.a     = cell_vtx[0];
   assign seg_req.b     = cell_vtx[1];

   pnp_seg u_seg (
      .clock (clock),
      .reset (reset),
      .req   (seg_req),
      .r2    (r2_ff),
      .rsp   (seg_rsp)
   );

endmodule

// File: src/pnp_checker.sv
// Port-level checker for point_near_polyline_check_top, with its bind.
// Depends on pnp_pkg for opcode and status codes.
module pnp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [pnp_pkg::OP_W-1:0]         req_opcode,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic [pnp_pkg::STATUS_W-1:0]     rsp_status
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_status))
      else $error("stalled result changed");

   // a hit is only ever reported with ok status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == pnp_pkg::STATUS_OK)
      else $error("hit with non-ok status");

   // anything but a query answers in the next cycle
   a_fast_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode != pnp_pkg::OP_QUERY) |=> rsp_valid)
      else $error("non-query item not answered in one cycle");

   // status code 3 is never produced
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == pnp_pkg::STATUS_OK) ||
                    (rsp_status == pnp_pkg::STATUS_FULL) ||
                    (rsp_status == pnp_pkg::STATUS_SHORT))
      else $error("undefined status code");

endmodule

bind point_near_polyline_check_top pnp_checker u_pnp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_hit    (rsp_hit),
   .rsp_status (rsp_status)
);
